### src/est_pkg.sv
package est_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SLOT_CW    = $clog2(SLOT_COUNT + 1);
  localparam int SLOT_IDX_W = 6;
  localparam int ID_W       = 8;

  typedef enum logic [2:0] {
    CMD_REGISTER   = 3'd0,
    CMD_UNREGISTER = 3'd1,
    CMD_PURGE      = 3'd2,
    CMD_WATCH      = 3'd3,
    CMD_UNWATCH    = 3'd4,
    CMD_TRIGGER    = 3'd5,
    CMD_HANDLE     = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic [2:0]      cmd;
    logic [ID_W-1:0] evt_tag;
    logic [7:0]      slot_number;
    logic            auto_enable;
    logic            disable_after_run;
    logic [7:0]      purge_count;
  } in_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic                  fired;
    logic                  last;
  } out_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            en;
    logic            trig;
    logic            dar;
  } entry_t;

  typedef struct packed {
    logic load;
    logic direct;
    logic run;
  } ctl_t;

  typedef struct packed {
    logic scan_last;
  } stat_t;

endpackage

### src/event_slot_table_top.sv
// Channel   Ports                        Transaction
// ------    ---------------------------  -----------------------------------
// in        start, busy, in_data         start high and busy low at the edge
// out       out_strobe, out_data         one cycle per result, no back pressure
//
// Unregister and the unused code need no scan; the result shows the next cycle.
// Register ends its scan at the first free slot, else scans all and reports full.
// Purge, watch, unwatch, trigger and handle make one pass of the
// slot RAM read port, one slot per cycle, then give a final result.
// Handle emits at most one result per cycle, holding each fired slot until
// the next is found. Reset marks every slot unused at once through the used
// flags. Results cannot be stalled.
module event_slot_table_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  est_pkg::in_t  in_data,
  output logic          out_strobe,
  output est_pkg::out_t out_data
);
  import est_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  est_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .cmd   (in_data.cmd),
    .stat  (stat),
    .busy  (busy),
    .ctl   (ctl)
  );

  est_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .ctl        (ctl),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  a_last_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    stat.scan_last |-> ctl.run)
    else $error("scan end outside a scan");

  a_direct_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.cmd == CMD_UNREGISTER) |=> (out_strobe && out_data.last))
    else $error("unregister result missing");

  a_busy_fall_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_strobe && out_data.last))
    else $error("scan ended without final result");

  a_notlast_fired: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.last) |-> out_data.fired)
    else $error("non-final result that is not a fired slot");

endmodule

### src/est_ctrl.sv
module est_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [2:0]     cmd,
  input  est_pkg::stat_t stat,
  output logic           busy,
  output est_pkg::ctl_t  ctl
);
  import est_pkg::*;

  state_t state_r, state_nxt;
  logic   scan_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    case (cmd_t'(cmd))
      CMD_REGISTER, CMD_PURGE, CMD_WATCH, CMD_UNWATCH,
      CMD_TRIGGER, CMD_HANDLE: scan_cmd = 1'b1;
      default:                 scan_cmd = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    ctl.load   = 1'b0;
    ctl.direct = 1'b0;
    ctl.run    = 1'b0;
    busy       = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load   = 1'b1;
          ctl.direct = !scan_cmd;
          if (scan_cmd) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ctl.run = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### src/est_datapath.sv
module est_datapath (
  input  logic          clk,
  input  logic          rst_n,
  input  est_pkg::in_t  in_data,
  input  est_pkg::ctl_t ctl,
  output est_pkg::stat_t stat,
  output logic          out_strobe,
  output est_pkg::out_t out_data
);
  import est_pkg::*;

  entry_t                mem [SLOT_COUNT];
  in_t                   item_r;
  logic [SLOT_COUNT-1:0] used_r, used_nxt;
  logic [SLOT_CW-1:0]    iss_cnt_r;
  logic [SLOT_AW-1:0]    ev_idx_r;
  logic                  ev_vld_r;
  logic                  fin_r;
  entry_t                rd_data_r;
  logic [8:0]            cnt_r, cnt_nxt;
  logic                  pend_vld_r, pend_vld_nxt;
  logic [SLOT_AW-1:0]    pend_idx_r, pend_idx_nxt;
  logic                  out_vld_r, out_vld_nxt;
  out_t                  out_r, out_nxt;

  logic   issue, eval_act, ev_used, ev_match, ev_last, fire;
  logic   we;
  entry_t wdata;

  assign issue    = ctl.run && (iss_cnt_r < SLOT_CW'(SLOT_COUNT));
  assign eval_act = ctl.run && ev_vld_r;
  assign ev_used  = used_r[ev_idx_r];
  assign ev_match = ev_used && (rd_data_r.id == item_r.evt_tag);
  assign ev_last  = (ev_idx_r == SLOT_AW'(SLOT_COUNT - 1));
  assign fire     = ev_used && rd_data_r.en && rd_data_r.trig;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[ev_idx_r] <= wdata;
    end
    if (issue) begin
      rd_data_r <= mem[iss_cnt_r[SLOT_AW-1:0]];
    end
  end

  always_comb begin
    used_nxt     = used_r;
    cnt_nxt      = cnt_r;
    pend_vld_nxt = pend_vld_r;
    pend_idx_nxt = pend_idx_r;
    we           = 1'b0;
    wdata        = rd_data_r;
    out_vld_nxt  = 1'b0;
    out_nxt      = '{status: ST_OK, slot_index: '0, fired: 1'b0, last: 1'b1};
    stat.scan_last = 1'b0;

    if (ctl.direct) begin
      out_vld_nxt = 1'b1;
      if (cmd_t'(in_data.cmd) == CMD_UNREGISTER) begin
        if ({1'b0, in_data.slot_number} >= 9'(SLOT_COUNT)) begin
          out_nxt.status = ST_RANGE;
        end else begin
          used_nxt[in_data.slot_number[SLOT_AW-1:0]] = 1'b0;
        end
      end
    end

    if (ctl.load) begin
      cnt_nxt      = '0;
      pend_vld_nxt = 1'b0;
    end

    if (eval_act) begin
      case (cmd_t'(item_r.cmd))
        CMD_REGISTER: begin
          if (!ev_used) begin
            we       = 1'b1;
            wdata    = '{id: item_r.evt_tag, en: item_r.auto_enable, trig: 1'b0,
                         dar: item_r.disable_after_run};
            used_nxt[ev_idx_r] = 1'b1;
            out_vld_nxt        = 1'b1;
            out_nxt.slot_index = SLOT_IDX_W'(ev_idx_r);
            stat.scan_last     = 1'b1;
          end
        end
        CMD_PURGE: begin
          if (ev_match && (cnt_r <= {1'b0, item_r.purge_count})) begin
            used_nxt[ev_idx_r] = 1'b0;
            cnt_nxt            = cnt_r + 9'd1;
          end
        end
        CMD_WATCH: begin
          if (ev_match) begin
            we       = 1'b1;
            wdata.en = 1'b1;
          end
        end
        CMD_UNWATCH: begin
          if (ev_match) begin
            we       = 1'b1;
            wdata.en = 1'b0;
          end
        end
        CMD_TRIGGER: begin
          if (ev_match && rd_data_r.en) begin
            we         = 1'b1;
            wdata.trig = 1'b1;
          end
        end
        CMD_HANDLE: begin
          if (fire) begin
            we         = 1'b1;
            wdata.trig = 1'b0;
            wdata.en   = rd_data_r.en && !rd_data_r.dar;
            if (pend_vld_r) begin
              out_vld_nxt        = 1'b1;
              out_nxt.slot_index = SLOT_IDX_W'(pend_idx_r);
              out_nxt.fired      = 1'b1;
              out_nxt.last       = 1'b0;
            end
            pend_vld_nxt = 1'b1;
            pend_idx_nxt = ev_idx_r;
          end
        end
        default: begin
        end
      endcase
    end

    if (ctl.run && fin_r) begin
      out_vld_nxt    = 1'b1;
      stat.scan_last = 1'b1;
      case (cmd_t'(item_r.cmd))
        CMD_REGISTER: begin
          out_nxt.status = ST_FULL;
        end
        CMD_HANDLE: begin
          if (pend_vld_r) begin
            out_nxt.slot_index = SLOT_IDX_W'(pend_idx_r);
            out_nxt.fired      = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      ev_vld_r   <= 1'b0;
      fin_r      <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      iss_cnt_r  <= '0;
    end else begin
      used_r     <= used_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      if (ctl.load) begin
        iss_cnt_r <= '0;
        ev_vld_r  <= 1'b0;
        fin_r     <= 1'b0;
      end else begin
        ev_vld_r <= issue;
        fin_r    <= eval_act && ev_last;
        if (issue) begin
          iss_cnt_r <= iss_cnt_r + SLOT_CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_r      <= out_nxt;
    if (ctl.load) begin
      item_r <= in_data;
    end
    if (issue) begin
      ev_idx_r <= iss_cnt_r[SLOT_AW-1:0];
    end
  end

  assign out_strobe = out_vld_r;
  assign out_data   = out_r;

endmodule
